FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
// Needs nothing else; take in with a bare-name include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define EER_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define EER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/eer_pkg.sv
// Package for the expiring entry ring: sizes, item structs, codes and state type.
// Depends on nothing; every other file but assert_macros.svh imports it.
package eer_pkg;

	localparam int RING_DEPTH = 64;
	localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);
	localparam int TICK_W     = 48;
	localparam int WORD_W     = 32;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic ACT_PUSH   = 1'b0;
	localparam logic ACT_REPLAY = 1'b1;

	typedef struct packed {
		logic              action;
		logic [1:0]        shape_kind;
		logic              coord_space;
		logic [WORD_W-1:0] color;
		logic [WORD_W-1:0] duration;
		logic [TICK_W-1:0] current_tick;
		logic [WORD_W-1:0] param_a;
		logic [WORD_W-1:0] param_b;
		logic [WORD_W-1:0] param_c;
		logic [WORD_W-1:0] param_d;
		logic [WORD_W-1:0] param_e;
	} cmd_t;

	typedef struct packed {
		logic              any_live;
		logic [1:0]        out_kind;
		logic              out_space;
		logic [WORD_W-1:0] out_color;
		logic [WORD_W-1:0] out_a;
		logic [WORD_W-1:0] out_b;
		logic [WORD_W-1:0] out_c;
		logic [WORD_W-1:0] out_d;
		logic [WORD_W-1:0] out_e;
		logic              last;
	} res_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              space;
		logic [WORD_W-1:0] color;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
	} rec_t;

	typedef struct packed {
		logic [TICK_W-1:0] expiry;
		rec_t              rec;
	} entry_t;

	typedef enum logic {
		TOP_ADD_SAT,
		TOP_GT
	} tick_op_t;

	typedef struct packed {
		logic [TICK_W-1:0] value;
		logic              flag;
	} tick_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_WALK,
		ST_DRAIN,
		ST_FINAL
	} state_t;

endpackage

FILE: src/eer_tick_unit.sv
// Shared tick arithmetic: one 49-bit adder serves the saturating expiry stamp
// and the expiry-versus-now compare. Depends on eer_pkg.
module eer_tick_unit (
	input  eer_pkg::tick_op_t            op,
	input  logic [eer_pkg::TICK_W-1:0]   a,
	input  logic [eer_pkg::TICK_W-1:0]   b,
	output eer_pkg::tick_res_t           res
);
	import eer_pkg::*;

	logic [TICK_W:0] x;
	logic [TICK_W:0] y;
	logic [TICK_W:0] sum;
	logic            cin;

	// Add: a + b, carry out means saturate. Compare: b - a, borrow means a > b.
	always_comb begin
		case (op)
			TOP_GT: begin
				x   = {1'b0, b};
				y   = ~{1'b0, a};
				cin = 1'b1;
			end
			default: begin
				x   = {1'b0, a};
				y   = {1'b0, b};
				cin = 1'b0;
			end
		endcase
		sum = x + y + {{TICK_W{1'b0}}, cin};
		res.flag  = sum[TICK_W];
		res.value = ((op == TOP_ADD_SAT) && sum[TICK_W]) ? TICK_MAX : sum[TICK_W-1:0];
	end

endmodule

FILE: src/eer_store.sv
// Slot memory of the ring: one write port, one registered read port.
// Depends on eer_pkg. Slots not yet written read back with a zero expiry.
module eer_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [eer_pkg::SLOT_W-1:0]   wr_addr,
	input  eer_pkg::entry_t              wr_data,
	input  logic                         rd_en,
	input  logic [eer_pkg::SLOT_W-1:0]   rd_addr,
	input  logic                         rd_written,
	output eer_pkg::entry_t              rd_data
);
	import eer_pkg::*;

	entry_t mem [RING_DEPTH];
	entry_t rdata_q;
	logic   written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= 1'b0;
		end else if (rd_en) begin
			written_q <= rd_written;
		end
	end

	// Mask the stamp of an unwritten slot so it always reads as expired.
	always_comb begin
		rd_data        = rdata_q;
		rd_data.expiry = written_q ? rdata_q.expiry : '0;
	end

endmodule

FILE: src/expiring_entry_ring.sv
// expiring_entry_ring: ring of RING_DEPTH timed shape records.
// Input channel: an item (cmd) is taken at a rising edge where start is high
// and busy is low. cmd.action selects push or replay.
// Push: stamps expiry = current_tick + duration (saturated to the 48-bit
// maximum), writes the write slot and advances it with wrap. Busy while
// the write is made; no result.
// Replay: walks every slot oldest first, one memory read per cycle, and
// emits each record whose expiry is above current_tick. Results appear on
// result for one cycle each, marked by strobe; result.last flags the final
// one, and an empty item (any_live = 0, last = 1) is sent when nothing is
// live. Busy through the walk, drain and final states; the final
// result shows in the cycle busy drops. The walk is paced by the single
// read port of the slot memory. Each live record
// is held until the next one (or the end of the walk) tells whether it is
// the last: a non-final result is registered once the store's read register
// shows the next live slot; the final one is registered in the final state.
// The receiver cannot stall: each result is taken in its strobe cycle.
// Reset (arst_n low, asynchronous): ring empty, write slot zero, no strobe.
// Depends on eer_pkg, eer_tick_unit and eer_store.
module expiring_entry_ring (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  eer_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            strobe,
	output eer_pkg::res_t   result
);
	import eer_pkg::*;

	state_t             state_q;
	state_t             state_next;
	cmd_t               cmd_q;
	logic [SLOT_W-1:0]  wr_slot_q;
	logic [CNT_W-1:0]   fill_q;
	logic [SLOT_W-1:0]  rd_slot_q;
	logic [SLOT_W-1:0]  issue_cnt_q;
	logic               rd_vld_s1;
	rec_t               hold_q;
	logic               hold_vld_q;
	res_t               res_q;
	logic               strobe_q;

	logic               accept;
	logic               wr_en;
	logic               rd_en;
	logic               rd_written;
	entry_t             wr_data;
	entry_t             rd_data;
	tick_op_t           tick_op;
	logic [TICK_W-1:0]  tick_a;
	logic [TICK_W-1:0]  tick_b;
	tick_res_t          tick_res;
	logic               live;
	logic               emit_mid;
	logic               emit_final;
	logic               walk_done;
	logic [SLOT_W-1:0]  wr_slot_next;
	logic [SLOT_W-1:0]  rd_slot_next;
	logic [SLOT_W-1:0]  walk_first;

	function automatic res_t rec_to_res(input rec_t r, input logic is_last);
		res_t o;
		o.any_live  = 1'b1;
		o.out_kind  = r.kind;
		o.out_space = r.space;
		o.out_color = r.color;
		o.out_a     = r.a;
		o.out_b     = r.b;
		o.out_c     = r.c;
		o.out_d     = r.d;
		o.out_e     = r.e;
		o.last      = is_last;
		return o;
	endfunction

	// Empty replay item: every field clear but last.
	function automatic res_t empty_res();
		res_t o;
		o      = '0;
		o.last = 1'b1;
		return o;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	assign accept     = start && (state_q == ST_IDLE);
	assign walk_done  = (issue_cnt_q == SLOT_W'(RING_DEPTH - 1));
	assign wr_slot_next = slot_inc(wr_slot_q);
	assign rd_slot_next = slot_inc(rd_slot_q);
	// Oldest record: slot zero until the ring has wrapped, else the write slot.
	assign walk_first = (fill_q < CNT_W'(RING_DEPTH)) ? '0 : wr_slot_q;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = (cmd.action == ACT_PUSH) ? ST_PUSH : ST_WALK;
				end
			end
			ST_PUSH:  state_next = ST_IDLE;
			ST_WALK: begin
				if (walk_done) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: state_next = ST_FINAL;
			ST_FINAL: state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	// Decode: memory strobes and the operands of the shared tick unit
	always_comb begin
		busy    = 1'b1;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		tick_op = TOP_GT;
		tick_a  = rd_data.expiry;
		tick_b  = cmd_q.current_tick;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_PUSH: begin
				wr_en   = 1'b1;
				tick_op = TOP_ADD_SAT;
				tick_a  = cmd_q.current_tick;
				tick_b  = TICK_W'(cmd_q.duration);
			end
			ST_WALK:  rd_en = 1'b1;
			ST_DRAIN: ;
			ST_FINAL: ;
			default:  busy = 1'b1;
		endcase
	end

	eer_tick_unit u_tick (
		.op  (tick_op),
		.a   (tick_a),
		.b   (tick_b),
		.res (tick_res)
	);

	// Slots below the fill count are exactly the ones written so far.
	assign rd_written = (CNT_W'(rd_slot_q) < fill_q);

	always_comb begin
		wr_data.expiry    = tick_res.value;
		wr_data.rec.kind  = cmd_q.shape_kind;
		wr_data.rec.space = cmd_q.coord_space;
		wr_data.rec.color = cmd_q.color;
		wr_data.rec.a     = cmd_q.param_a;
		wr_data.rec.b     = cmd_q.param_b;
		wr_data.rec.c     = cmd_q.param_c;
		wr_data.rec.d     = cmd_q.param_d;
		wr_data.rec.e     = cmd_q.param_e;
	end

	eer_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_slot_q),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_slot_q),
		.rd_written (rd_written),
		.rd_data    (rd_data)
	);

	// A live record releases the one held before it as a non-final item.
	assign live       = rd_vld_s1 && (tick_op == TOP_GT) && tick_res.flag;
	assign emit_mid   = live && hold_vld_q;
	assign emit_final = (state_q == ST_FINAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_slot_q   <= '0;
			fill_q      <= '0;
			rd_slot_q   <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			hold_vld_q  <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			state_q   <= state_next;
			rd_vld_s1 <= rd_en;
			strobe_q  <= emit_mid || emit_final;
			if (accept) begin
				rd_slot_q   <= walk_first;
				issue_cnt_q <= '0;
				hold_vld_q  <= 1'b0;
			end
			if (rd_en) begin
				rd_slot_q   <= rd_slot_next;
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			if (live) begin
				hold_vld_q <= 1'b1;
			end
			// Advance the write slot, grow the fill count up to the depth
			if (wr_en) begin
				wr_slot_q <= wr_slot_next;
				if (fill_q < CNT_W'(RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// Payload: latched command, held record, result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (live) begin
			hold_q <= rd_data.rec;
		end
		if (emit_mid) begin
			res_q <= rec_to_res(hold_q, 1'b0);
		end else if (emit_final) begin
			if (hold_vld_q) begin
				res_q <= rec_to_res(hold_q, 1'b1);
			end else begin
				res_q <= empty_res();
			end
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

FILE: src/eer_checker.sv
// Port-level checker for expiring_entry_ring, bound to the top level below.
// Depends on eer_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eer_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  eer_pkg::cmd_t   cmd,
	input  logic            busy,
	input  logic            strobe,
	input  eer_pkg::res_t   result
);
	import eer_pkg::*;

	// An accepted item always makes the block busy in the following cycle.
	`EER_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")

	// More results follow a non-final one, so the block must still be working.
	`EER_ASSERT_IMPLY(a_mid_busy, clk, arst_n, strobe && !result.last, busy, "non-final result while idle")

	// The empty item is always the only and final one.
	`EER_ASSERT_IMPLY(a_empty_last, clk, arst_n, strobe && !result.any_live, result.last, "empty item without last")

	// A push produces no result.
	`EER_ASSERT_NEXT(a_push_quiet, clk, arst_n, start && !busy && (cmd.action == ACT_PUSH), !strobe, "result after push")

endmodule

bind expiring_entry_ring eer_checker u_eer_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);

FILE: tb/expiring_entry_ring_test.sv
// Self-checking bench for expiring_entry_ring: pushes and replays against a shadow ring.
// Depends on eer_pkg and the expiring_entry_ring top level; reads and writes no files.
module expiring_entry_ring_test;
	timeunit 1ns;
	timeprecision 1ps;

	import eer_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500_000;
	localparam int          TAIL_CYCLES = RING_DEPTH + 8;

	// Shadow of the ring: expiry stamps and records, plus the results that
	// replays have promised but the block has not yet sent.
	class ring_shadow;
		logic [TICK_W-1:0] shadow_expiry [RING_DEPTH];
		rec_t              shadow_rec [RING_DEPTH];
		int unsigned       wr_slot;
		int unsigned       fill;
		res_t              due_results [$];
		int                errors;

		function new();
			foreach (shadow_expiry[i]) begin
				shadow_expiry[i] = '0;
				shadow_rec[i]    = '0;
			end
			wr_slot = 0;
			fill    = 0;
			errors  = 0;
		endfunction

		// Fold an accepted item into the shadow; a replay queues what it must emit.
		function void take_cmd(cmd_t c);
			logic [TICK_W:0] sum;
			int unsigned     first_slot;
			int unsigned     slot;
			res_t            held;
			bit              have_held;
			if (c.action == ACT_PUSH) begin
				sum = {1'b0, c.current_tick} + {{(TICK_W + 1 - WORD_W){1'b0}}, c.duration};
				shadow_expiry[wr_slot]    = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
				shadow_rec[wr_slot].kind  = c.shape_kind;
				shadow_rec[wr_slot].space = c.coord_space;
				shadow_rec[wr_slot].color = c.color;
				shadow_rec[wr_slot].a     = c.param_a;
				shadow_rec[wr_slot].b     = c.param_b;
				shadow_rec[wr_slot].c     = c.param_c;
				shadow_rec[wr_slot].d     = c.param_d;
				shadow_rec[wr_slot].e     = c.param_e;
				wr_slot = (wr_slot + 1) % RING_DEPTH;
				if (fill < RING_DEPTH)
					fill++;
			end else begin
				// Walk oldest first; hold each live record until the next one
				// shows whether it is the last.
				first_slot = (fill < RING_DEPTH) ? 0 : wr_slot;
				have_held  = 1'b0;
				held       = '0;
				for (int k = 0; k < RING_DEPTH; k++) begin
					slot = (first_slot + k) % RING_DEPTH;
					if (shadow_expiry[slot] > c.current_tick) begin
						if (have_held)
							due_results.push_back(held);
						held           = '0;
						held.any_live  = 1'b1;
						held.out_kind  = shadow_rec[slot].kind;
						held.out_space = shadow_rec[slot].space;
						held.out_color = shadow_rec[slot].color;
						held.out_a     = shadow_rec[slot].a;
						held.out_b     = shadow_rec[slot].b;
						held.out_c     = shadow_rec[slot].c;
						held.out_d     = shadow_rec[slot].d;
						held.out_e     = shadow_rec[slot].e;
						have_held      = 1'b1;
					end
				end
				// Nothing live: a single empty item, all fields clear but last.
				if (!have_held)
					held = '0;
				held.last = 1'b1;
				due_results.push_back(held);
			end
		endfunction

		function void cmp(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t r);
			res_t want;
			if (due_results.size() == 0) begin
				$error("result with nothing due: live %0b kind %0d colour %0h last %0b",
					r.any_live, r.out_kind, r.out_color, r.last);
				errors++;
			end else begin
				want = due_results.pop_front();
				cmp("any_live",  32'(want.any_live),  32'(r.any_live));
				cmp("out_kind",  32'(want.out_kind),  32'(r.out_kind));
				cmp("out_space", 32'(want.out_space), 32'(r.out_space));
				cmp("out_color", want.out_color, r.out_color);
				cmp("out_a",     want.out_a,     r.out_a);
				cmp("out_b",     want.out_b,     r.out_b);
				cmp("out_c",     want.out_c,     r.out_c);
				cmp("out_d",     want.out_d,     r.out_d);
				cmp("out_e",     want.out_e,     r.out_e);
				cmp("last",      32'(want.last),      32'(r.last));
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	cmd_t  cmd;
	logic  busy;
	logic  strobe;
	res_t  result;

	ring_shadow        ring;
	int                idle_pct;
	logic [TICK_W-1:0] tick_base;
	int unsigned       cycles;

	expiring_entry_ring dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the whole run; a hung handshake ends here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("expiring_entry_ring_test NOT OK");
			$finish;
		end
	end

	// Every strobe is a result taken at this edge; the block never waits for us.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			ring.check_result(result);
	end

	// Gap before the next item: geometric at the phase's idle rate, now and then
	// a long one so that the pause lands anywhere in a replay walk or after it.
	function automatic int pick_gap();
		int g;
		g = 0;
		if (idle_pct == 0)
			return 0;
		if ($urandom_range(0, 7) == 0)
			return int'($urandom_range(0, RING_DEPTH + 8));
		while (g < 40 && int'($urandom_range(0, 99)) < idle_pct)
			g++;
		return g;
	endfunction

	function automatic cmd_t mk_push(logic [1:0] kind, logic space, logic [WORD_W-1:0] word,
			logic [WORD_W-1:0] dur, logic [TICK_W-1:0] tick);
		cmd_t c;
		c.action       = ACT_PUSH;
		c.shape_kind   = kind;
		c.coord_space  = space;
		c.color        = word;
		c.duration     = dur;
		c.current_tick = tick;
		c.param_a      = word;
		c.param_b      = ~word;
		c.param_c      = word;
		c.param_d      = ~word;
		c.param_e      = word;
		return c;
	endfunction

	// Replay fields other than the tick are don't-care; fill them with noise.
	function automatic cmd_t mk_replay(logic [TICK_W-1:0] tick);
		cmd_t c;
		c.action       = ACT_REPLAY;
		c.shape_kind   = 2'($urandom_range(0, 3));
		c.coord_space  = 1'($urandom_range(0, 1));
		c.color        = $urandom();
		c.duration     = $urandom();
		c.current_tick = tick;
		c.param_a      = $urandom();
		c.param_b      = $urandom();
		c.param_c      = $urandom();
		c.param_d      = $urandom();
		c.param_e      = $urandom();
		return c;
	endfunction

	function automatic logic [TICK_W-1:0] any_tick();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TICK_W-1:0];
	endfunction

	// Mostly pushes against a slowly advancing clock, so the ring wraps often and
	// replays see a mix of live and stale records; now and then jump the clock
	// to zero, to near the top or anywhere.
	function automatic cmd_t rand_cmd();
		cmd_t              c;
		int                sel;
		logic [WORD_W-1:0] dur;
		logic [TICK_W-1:0] tick;
		sel = int'($urandom_range(0, 49));
		if (sel == 0)
			tick_base = '0;
		else if (sel == 1)
			tick_base = TICK_MAX - TICK_W'($urandom_range(0, 400));
		else if (sel == 2)
			tick_base = any_tick();
		else
			tick_base = tick_base + TICK_W'($urandom_range(0, 40));
		if ($urandom_range(0, 99) < 72) begin
			sel = int'($urandom_range(0, 9));
			if (sel == 0)
				dur = '0;
			else if (sel == 1)
				dur = '1;
			else if (sel == 2)
				dur = $urandom();
			else
				dur = WORD_W'($urandom_range(1, 600));
			c = mk_push(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom(),
				dur, tick_base);
			c.param_a = $urandom();
			c.param_b = $urandom();
			c.param_c = $urandom();
			c.param_d = $urandom();
			c.param_e = $urandom();
		end else begin
			sel = int'($urandom_range(0, 19));
			if (sel == 0)
				tick = '0;
			else if (sel == 1)
				tick = TICK_MAX;
			else if (sel == 2)
				tick = any_tick();
			else
				tick = tick_base + TICK_W'($urandom_range(0, 300));
			c = mk_replay(tick);
		end
		return c;
	endfunction

	// Offer one item and hold it until the block takes it, then fold it into the shadow.
	// Start stays high when the next item follows straight on.
	task automatic send_cmd(cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		ring.take_cmd(c);
	endtask

	initial begin
		int phase_pct [4];
		int waited;
		ring      = new();
		idle_pct  = 0;
		tick_base = '0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty ring, zero-length and saturating stamps, the exact
		// saturation boundary, kind three, and replays either side of an expiry.
		send_cmd(mk_replay('0));
		send_cmd(mk_push(2'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, '0));
		send_cmd(mk_push(2'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TICK_MAX));
		send_cmd(mk_push(2'd1, 1'b0, 32'hAAAA_AAAA, 32'd50, 48'd100));
		send_cmd(mk_push(2'd2, 1'b1, 32'h5555_5555, 32'd5, TICK_MAX - 48'd5));
		send_cmd(mk_push(2'd2, 1'b0, 32'h0F0F_0F0F, 32'd6, TICK_MAX - 48'd5));
		send_cmd(mk_push(2'd0, 1'b1, 32'h1234_5678, 32'h8000_0000, 48'h7FFF_FFFF_FFFF));
		send_cmd(mk_replay('0));
		send_cmd(mk_replay(48'd149));
		send_cmd(mk_replay(48'd150));
		send_cmd(mk_replay(TICK_MAX - 48'd1));
		send_cmd(mk_replay(TICK_MAX));
		send_cmd(mk_replay(48'h8000_0000_0000));

		// Random stretches: flat out, sender mostly idle, flat out again, light idling.
		phase_pct = '{0, 64, 0, 17};
		foreach (phase_pct[p]) begin
			idle_pct = phase_pct[p];
			repeat (115) send_cmd(rand_cmd());
		end

		// Drop start, drain what replays still owe, then watch for strays.
		start <= 1'b0;
		waited = 0;
		while (ring.due_results.size() != 0 && waited < 8 * RING_DEPTH) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ring.due_results.size() != 0) begin
			$error("%0d results never arrived", ring.due_results.size());
			ring.errors++;
		end

		if (ring.errors == 0)
			$display("expiring_entry_ring_test OK");
		else
			$display("expiring_entry_ring_test NOT OK");
		$finish;
	end

endmodule
